### src/brle_pkg.sv
// Shared constants and types for the byte run-length encoder.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package brle_pkg;

  localparam int MIN_REPEAT_DEF   = 3;
  localparam int MAX_LITERALS_DEF = 128;
  localparam int MAX_REPEAT_DEF   = 130;
  localparam int WORD_BYTES_DEF   = 8;

  // request codes on req_type
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // one encoded byte (or the empty end item) handed to the word packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       final_byte;
    logic       eos;
    logic       empty;
  } pack_req_t;

endpackage

### src/brle_if.sv
// Valid/ready channel interfaces for the byte run-length encoder.
// Independent of the package; compiled after it.
`timescale 1ns / 1ps

interface brle_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        end_of_stream;

  modport source (output valid, output out_word, output byte_count,
                  output last_of_run, output end_of_stream, input ready);
  modport sink   (input valid, input out_word, input byte_count,
                  input last_of_run, input end_of_stream, output ready);
endinterface

### src/byte_run_length_encoder_unit.sv
// Top level of the byte run-length encoder: run/literal tracking, literal
// store and the drain sequencer. Depends on brle_pkg, brle_if, brle_word_packer.
`timescale 1ns / 1ps

//  channel  | dir | payload                                            | handshake
//  in_ch    | in  | req_type, data_byte                                | valid/ready
//  out_ch   | out | out_word, byte_count, last_of_run, end_of_stream   | valid/ready
//
//  An append that completes no group is accepted without leaving ST_IDLE. A
//  group that drains is accepted in ST_IDLE, then sends its control byte in
//  ST_CTRL and its body in ST_BODY: one byte for a run, n for n literals, all
//  through the one byte lane into the packer. An empty flush passes ST_EMPTY.
//  Reset is synchronous, active low; the literal store needs no clearing.
//  A word waiting on out_ch.ready stalls only an item that loads the next word.

module byte_run_length_encoder_unit #(
  parameter int MIN_REPEAT   = brle_pkg::MIN_REPEAT_DEF,
  parameter int MAX_LITERALS = brle_pkg::MAX_LITERALS_DEF,
  parameter int MAX_REPEAT   = brle_pkg::MAX_REPEAT_DEF,
  parameter int WORD_BYTES   = brle_pkg::WORD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  brle_in_if.sink    in_ch,
  brle_out_if.source out_ch
);

  localparam int PEND_MAX = (MAX_LITERALS > MAX_REPEAT) ? MAX_LITERALS : MAX_REPEAT;
  localparam int PEND_W   = $clog2(PEND_MAX + 1);
  localparam int ADDR_W   = $clog2(MAX_LITERALS);
  localparam int TAIL_W   = $clog2(MIN_REPEAT + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CTRL, ST_BODY, ST_EMPTY} state_t;

  state_t            state_r;
  logic [PEND_W-1:0] pend_r;
  logic              rep_r;
  logic [TAIL_W-1:0] tail_r;
  logic [7:0]        first_r;
  logic [7:0]        last_r;
  logic              lit_r;
  logic [7:0]        ctrl_r;
  logic [PEND_W-1:0] body_left_r;
  logic [7:0]        run_byte_r;
  logic              flush_r;
  logic              wr_pend_r;
  logic [7:0]        hold_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [7:0]        mem_q_r;

  logic [7:0] store_mem [MAX_LITERALS];

  // accept-side decisions
  logic              accept;
  logic [7:0]        v;
  logic [TAIL_W-1:0] tail_inc;
  logic [PEND_W-1:0] pend_inc;
  logic [PEND_W-1:0] pend_nxt;
  logic              rep_nxt;
  logic [TAIL_W-1:0] tail_nxt;
  logic [7:0]        first_nxt;
  logic [7:0]        last_nxt;
  logic              d_go;
  logic              d_lit;
  logic [PEND_W-1:0] d_len;
  logic              d_defer;
  logic              d_empty;
  logic              imm_wr;
  logic [ADDR_W-1:0] imm_addr;
  logic [7:0]        len8;
  logic [7:0]        ctrl_nxt;

  brle_pkg::pack_req_t pk_req;
  logic                pk_take;
  logic                body_final;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [7:0]          mem_wd;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign v           = in_ch.data_byte;
  assign tail_inc    = (v == last_r) ? tail_r + TAIL_W'(1) : TAIL_W'(1);
  assign pend_inc    = pend_r + PEND_W'(1);

  always_comb begin
    pend_nxt  = pend_r;
    rep_nxt   = rep_r;
    tail_nxt  = tail_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    d_go      = 1'b0;
    d_lit     = 1'b0;
    d_len     = pend_r;
    d_defer   = 1'b0;
    d_empty   = 1'b0;
    imm_wr    = 1'b0;
    imm_addr  = '0;
    if (in_ch.req_type == brle_pkg::REQ_FLUSH) begin
      if (pend_r == '0) begin
        d_empty = 1'b1;
      end else begin
        d_go     = 1'b1;
        d_lit    = !rep_r;
        pend_nxt = '0;
        rep_nxt  = 1'b0;
        tail_nxt = '0;
      end
    end else if (pend_r == '0) begin
      imm_wr    = 1'b1;
      pend_nxt  = PEND_W'(1);
      tail_nxt  = TAIL_W'(1);
      first_nxt = v;
      last_nxt  = v;
    end else if (rep_r) begin
      if (v == first_r) begin
        if (pend_inc >= PEND_W'(MAX_REPEAT)) begin
          d_go     = 1'b1;
          d_len    = pend_inc;
          pend_nxt = '0;
          rep_nxt  = 1'b0;
          tail_nxt = '0;
        end else begin
          pend_nxt = pend_inc;
        end
      end else begin
        // close the run, start afresh once it has drained
        d_go      = 1'b1;
        d_defer   = 1'b1;
        pend_nxt  = PEND_W'(1);
        rep_nxt   = 1'b0;
        tail_nxt  = TAIL_W'(1);
        first_nxt = v;
        last_nxt  = v;
      end
    end else if (tail_inc == TAIL_W'(MIN_REPEAT)) begin
      if (pend_inc == PEND_W'(MIN_REPEAT)) begin
        // every pending literal is equal: turn into a run
        rep_nxt  = 1'b1;
        pend_nxt = pend_inc;
        tail_nxt = tail_inc;
      end else begin
        // emit literals ahead of the equal tail, tail becomes the run
        d_go      = 1'b1;
        d_lit     = 1'b1;
        d_len     = pend_r - PEND_W'(MIN_REPEAT - 1);
        d_defer   = 1'b1;
        rep_nxt   = 1'b1;
        pend_nxt  = PEND_W'(MIN_REPEAT);
        tail_nxt  = '0;
        first_nxt = v;
        last_nxt  = v;
      end
    end else begin
      imm_wr   = 1'b1;
      imm_addr = pend_r[ADDR_W-1:0];
      pend_nxt = pend_inc;
      tail_nxt = tail_inc;
      last_nxt = v;
      if (pend_inc >= PEND_W'(MAX_LITERALS)) begin
        d_go     = 1'b1;
        d_lit    = 1'b1;
        d_len    = pend_inc;
        pend_nxt = '0;
        rep_nxt  = 1'b0;
        tail_nxt = '0;
      end
    end
  end

  assign len8     = 8'(d_len);
  assign ctrl_nxt = d_lit ? (8'd0 - len8) : (len8 - 8'(MIN_REPEAT));

  // byte lane into the packer
  assign body_final = (body_left_r == PEND_W'(1));

  always_comb begin
    pk_req            = '0;
    pk_req.valid      = (state_r == ST_CTRL) || (state_r == ST_BODY);
    pk_req.data       = (state_r == ST_CTRL) ? ctrl_r : (lit_r ? mem_q_r : run_byte_r);
    pk_req.final_byte = (state_r == ST_BODY) && body_final;
    pk_req.eos        = flush_r;
    pk_req.empty      = (state_r == ST_EMPTY);
  end

  brle_word_packer #(
    .WORD_BYTES(WORD_BYTES)
  ) u_packer (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (pk_req),
    .take   (pk_take),
    .out_ch (out_ch)
  );

  // literal store: one write port, one registered read port
  assign mem_we = (accept && imm_wr) ||
                  ((state_r == ST_BODY) && pk_take && body_final && wr_pend_r);
  assign mem_wa = (state_r == ST_IDLE) ? imm_addr : '0;
  assign mem_wd = (state_r == ST_IDLE) ? v : hold_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_take && pk_req.valid) begin
      mem_q_r <= store_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_r    <= '0;
      rep_r     <= 1'b0;
      tail_r    <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            pend_r      <= pend_nxt;
            rep_r       <= rep_nxt;
            tail_r      <= tail_nxt;
            first_r     <= first_nxt;
            last_r      <= last_nxt;
            lit_r       <= d_lit;
            ctrl_r      <= ctrl_nxt;
            body_left_r <= d_lit ? d_len : PEND_W'(1);
            run_byte_r  <= first_r;
            flush_r     <= (in_ch.req_type == brle_pkg::REQ_FLUSH);
            wr_pend_r   <= d_defer;
            hold_r      <= v;
            rd_idx_r    <= '0;
            if (d_go) begin
              state_r <= ST_CTRL;
            end else if (d_empty) begin
              state_r <= ST_EMPTY;
            end
          end
        end
        ST_CTRL: begin
          if (pk_take) begin
            rd_idx_r <= rd_idx_r + ADDR_W'(1);
            state_r  <= ST_BODY;
          end
        end
        ST_BODY: begin
          if (pk_take) begin
            rd_idx_r    <= rd_idx_r + ADDR_W'(1);
            body_left_r <= body_left_r - PEND_W'(1);
            if (body_final) begin
              wr_pend_r <= 1'b0;
              state_r   <= ST_IDLE;
            end
          end
        end
        ST_EMPTY: begin
          if (pk_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> (pend_r >= PEND_W'(MIN_REPEAT)) && (pend_r < PEND_W'(MAX_REPEAT)))
    else $error("pending run length out of range");

  a_lit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !rep_r |-> (pend_r < PEND_W'(MAX_LITERALS)) && (tail_r < TAIL_W'(MIN_REPEAT)))
    else $error("pending literal state out of range");

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY) |-> (body_left_r != '0))
    else $error("body count exhausted while draining");

endmodule

### src/brle_word_packer.sv
// Packs encoded bytes into output words, first byte lowest, and holds the
// output register. Depends on brle_pkg and brle_out_if.
`timescale 1ns / 1ps

module brle_word_packer #(
  parameter int WORD_BYTES = brle_pkg::WORD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brle_pkg::pack_req_t req,
  output logic                take,
  brle_out_if.source          out_ch
);

  localparam int FILL_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  logic [FILL_W-1:0] fill_r;
  logic [63:0]       acc_r;
  logic              out_valid_r;
  logic [63:0]       out_word_r;
  logic [3:0]        out_count_r;
  logic              out_last_r;
  logic              out_eos_r;

  logic        out_free;
  logic        completes;
  logic        load;
  logic [63:0] word_nxt;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign completes = req.final_byte || (fill_r == FILL_W'(WORD_BYTES - 1));
  assign take      = (req.valid && (!completes || out_free)) || (req.empty && out_free);
  // a new word enters the output register on this beat
  assign load      = take && ((req.valid && completes) || req.empty);
  // insert the byte at its lane
  assign word_nxt  = acc_r | (64'(req.data) << {fill_r, 3'b000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (req.valid && take) begin
        if (completes) begin
          out_word_r  <= word_nxt;
          out_count_r <= 4'(fill_r) + 4'd1;
          out_last_r  <= req.final_byte;
          out_eos_r   <= req.final_byte && req.eos;
          acc_r       <= '0;
          fill_r      <= '0;
        end else begin
          acc_r  <= word_nxt;
          fill_r <= fill_r + FILL_W'(1);
        end
      end else if (req.empty && take) begin
        out_word_r  <= '0;
        out_count_r <= 4'd0;
        out_last_r  <= 1'b1;
        out_eos_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_word      = out_word_r;
  assign out_ch.byte_count    = out_count_r;
  assign out_ch.last_of_run   = out_last_r;
  assign out_ch.end_of_stream = out_eos_r;

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_count_r == 4'd0) |-> out_last_r && out_eos_r)
    else $error("empty word without end marks");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= 4'(WORD_BYTES))
    else $error("byte count beyond word size");

  a_inner_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_count_r == 4'(WORD_BYTES))
    else $error("non-final word not full");

endmodule
